// ----- rtl/core/shw_pkg.sv -----
// Shared constants, payload types, state encoding and coefficient table for the window core.
`default_nettype none

package shw_pkg;

  // Default geometry of the sample ring.
  localparam int unsigned SHW_FRAME_LEN = 16;
  localparam int unsigned SHW_FRAMES    = 4;

  // Window length is fixed by the coefficient table below.
  localparam int unsigned WINDOW_LEN = 64;
  localparam int unsigned KW         = $clog2(WINDOW_LEN);

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned VALUE_W  = 31;

  // Item function codes.
  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample;
  } shw_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] windowed_value;
    logic                      window_last;
  } shw_out_t;

  // One read issued to the multiply pipeline.
  typedef struct packed {
    logic              vld;
    logic              last;
    logic [COEF_W-1:0] coef;
  } shw_tag_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EMIT
  } shw_state_e;

  // Periodic Hamming window, unsigned Q1.15, w[k] = 0.54 - 0.46*cos(2*pi*k/64).
  localparam logic [COEF_W-1:0] COEF_ROM [WINDOW_LEN] = '{
    16'd2621,  16'd2694,  16'd2911,  16'd3270,  16'd3769,  16'd4401,  16'd5162,  16'd6043,
    16'd7036,  16'd8132,  16'd9320,  16'd10589, 16'd11926, 16'd13319, 16'd14754, 16'd16217,
    16'd17695, 16'd19172, 16'd20635, 16'd22070, 16'd23463, 16'd24800, 16'd26069, 16'd27257,
    16'd28353, 16'd29347, 16'd30228, 16'd30988, 16'd31621, 16'd32119, 16'd32478, 16'd32695,
    16'd32768, 16'd32695, 16'd32478, 16'd32119, 16'd31621, 16'd30988, 16'd30228, 16'd29347,
    16'd28353, 16'd27257, 16'd26069, 16'd24800, 16'd23463, 16'd22070, 16'd20635, 16'd19172,
    16'd17695, 16'd16217, 16'd14754, 16'd13319, 16'd11926, 16'd10589, 16'd9320,  16'd8132,
    16'd7036,  16'd6043,  16'd5162,  16'd4401,  16'd3769,  16'd3270,  16'd2911,  16'd2694
  };

endpackage

`default_nettype wire

// ----- rtl/core/shw_ring.sv -----
// Sample ring memory: one write port, one read port with registered read data.
`default_nettype none

module shw_ring #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire                                    clk_i,
  input  wire                                    we_i,
  input  wire  [AW-1:0]                          waddr_i,
  input  wire  signed [shw_pkg::SAMPLE_W-1:0]    wdata_i,
  input  wire                                    re_i,
  input  wire  [AW-1:0]                          raddr_i,
  output logic signed [shw_pkg::SAMPLE_W-1:0]    rdata_o
);

  logic signed [shw_pkg::SAMPLE_W-1:0] mem_q [DEPTH];
  logic signed [shw_pkg::SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/shw_mul.sv -----
// Shared multiply pipeline: ring sample times window coefficient, two register stages.
`default_nettype none

module shw_mul (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  adv_i,
  input  shw_pkg::shw_tag_t                    tag_i,
  input  wire  signed [shw_pkg::SAMPLE_W-1:0]  rdata_i,
  output logic                                 vld_o,
  output shw_pkg::shw_out_t                    res_o
);

  logic                              s1_vld_q;
  logic                              s1_last_q;
  logic [shw_pkg::COEF_W-1:0]        s1_coef_q;
  logic                              s2_vld_q;
  logic                              s2_last_q;
  logic signed [shw_pkg::VALUE_W-1:0] s2_prod_q;
  logic signed [shw_pkg::SAMPLE_W+shw_pkg::COEF_W:0] prod_full;

  // Coefficient is unsigned: widen with a zero before the signed multiply.
  assign prod_full = rdata_i * $signed({1'b0, s1_coef_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q <= tag_i.vld;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_last_q <= tag_i.last;
      s1_coef_q <= tag_i.coef;
      s2_last_q <= s1_last_q;
      s2_prod_q <= prod_full[shw_pkg::VALUE_W-1:0];
    end
  end

  assign vld_o              = s2_vld_q;
  assign res_o.windowed_value = s2_prod_q;
  assign res_o.window_last  = s2_last_q;

endmodule

`default_nettype wire

// ----- rtl/core/shw_ctrl.sv -----
// Sequencer: ring pointers, clearing sweep, sample writes and window read issue.
`default_nettype none

module shw_ctrl #(
  parameter int unsigned FRAME_LEN = shw_pkg::SHW_FRAME_LEN,
  parameter int unsigned FRAMES    = shw_pkg::SHW_FRAMES,
  parameter int unsigned RING_LEN  = FRAME_LEN * FRAMES,
  parameter int unsigned AW        = (RING_LEN > 1) ? $clog2(RING_LEN) : 1
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  input  shw_pkg::shw_in_t                     in_data_i,
  output logic                                 in_stall_o,
  input  wire                                  adv_i,
  output logic                                 we_o,
  output logic [AW-1:0]                        waddr_o,
  output logic signed [shw_pkg::SAMPLE_W-1:0]  wdata_o,
  output logic                                 re_o,
  output logic [AW-1:0]                        raddr_o,
  output shw_pkg::shw_tag_t                    tag_o
);

  localparam int unsigned FW      = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
  localparam logic [AW-1:0] WR_INIT  = AW'((FRAMES - 1) * FRAME_LEN);
  localparam logic [AW-1:0] RING_TOP = AW'(RING_LEN - 1);
  localparam logic [AW-1:0] BASE_TOP = AW'(RING_LEN - FRAME_LEN);
  localparam logic [AW-1:0] HOP      = AW'(FRAME_LEN);
  localparam logic [FW-1:0] FILL_TOP = FW'(FRAME_LEN - 1);
  localparam logic [shw_pkg::KW-1:0] K_TOP = shw_pkg::KW'(shw_pkg::WINDOW_LEN - 1);

  shw_pkg::shw_state_e state_q, state_d;
  logic [AW-1:0]          clr_ptr_q, clr_ptr_d;
  logic [AW-1:0]          wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]          rd_base_q, rd_base_d;
  logic [AW-1:0]          rd_ptr_q, rd_ptr_d;
  logic [FW-1:0]          fill_q, fill_d;
  logic [shw_pkg::KW-1:0] k_q, k_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= shw_pkg::ST_CLEAR;
      clr_ptr_q <= '0;
      wr_ptr_q  <= WR_INIT;
      rd_base_q <= '0;
      rd_ptr_q  <= '0;
      fill_q    <= '0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      clr_ptr_q <= clr_ptr_d;
      wr_ptr_q  <= wr_ptr_d;
      rd_base_q <= rd_base_d;
      rd_ptr_q  <= rd_ptr_d;
      fill_q    <= fill_d;
      k_q       <= k_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_ptr_d  = clr_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    rd_base_d  = rd_base_q;
    rd_ptr_d   = rd_ptr_q;
    fill_d     = fill_q;
    k_d        = k_q;
    in_stall_o = 1'b1;
    we_o       = 1'b0;
    waddr_o    = wr_ptr_q;
    wdata_o    = in_data_i.sample;
    re_o       = 1'b0;
    raddr_o    = rd_ptr_q;
    tag_o      = '0;

    case (state_q)
      shw_pkg::ST_CLEAR: begin
        // Zero one ring entry per cycle.
        we_o      = 1'b1;
        waddr_o   = clr_ptr_q;
        wdata_o   = '0;
        clr_ptr_d = clr_ptr_q + AW'(1);
        if (clr_ptr_q == RING_TOP) begin
          state_d = shw_pkg::ST_IDLE;
        end
      end

      shw_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_data_i.func == shw_pkg::FUNC_CLEAR) begin
            state_d   = shw_pkg::ST_CLEAR;
            clr_ptr_d = '0;
            wr_ptr_d  = WR_INIT;
            rd_base_d = '0;
            fill_d    = '0;
          end else begin
            we_o     = 1'b1;
            wr_ptr_d = (wr_ptr_q == RING_TOP) ? '0 : wr_ptr_q + AW'(1);
            if (fill_q == FILL_TOP) begin
              fill_d   = '0;
              k_d      = '0;
              rd_ptr_d = rd_base_q;
              state_d  = shw_pkg::ST_EMIT;
            end else begin
              fill_d = fill_q + FW'(1);
            end
          end
        end
      end

      shw_pkg::ST_EMIT: begin
        if (adv_i) begin
          re_o       = 1'b1;
          tag_o.vld  = 1'b1;
          tag_o.last = (k_q == K_TOP);
          tag_o.coef = shw_pkg::COEF_ROM[k_q];
          rd_ptr_d   = (rd_ptr_q == RING_TOP) ? '0 : rd_ptr_q + AW'(1);
          k_d        = k_q + shw_pkg::KW'(1);
          if (k_q == K_TOP) begin
            state_d   = shw_pkg::ST_IDLE;
            rd_base_d = (rd_base_q == BASE_TOP) ? '0 : rd_base_q + HOP;
          end
        end
      end

      default: begin
        state_d = shw_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/sliding_hamming_window_core.sv -----
// Top level of the sliding periodic Hamming window core over a ring of overlapped frames.
//
//   Channel | Direction | Payload            | Handshake
//   --------+-----------+--------------------+------------------------------
//   in      | input     | shw_in_t  (17 bit) | in_valid_i / in_stall_o
//   out     | output    | shw_out_t (32 bit) | out_valid_o / out_stall_i
//
// A push that completes a frame starts WINDOW_LEN (64) window reads, one read of the
// ring memory port per cycle while the output is not stalled; each result passes the
// ring read register with the first multiply stage, the product register and the
// output register. No item is taken while the window reads are being issued.
// Reset and every clear item start a sweep that zeroes the ring, one entry a cycle,
// all FRAMES*FRAME_LEN entries (64 by default); no item is taken meanwhile.
// A stall on a held result freezes the read pipeline in place; results are never dropped.
`default_nettype none

module sliding_hamming_window_core #(
  parameter int unsigned FRAME_LEN = shw_pkg::SHW_FRAME_LEN,
  parameter int unsigned FRAMES    = shw_pkg::SHW_FRAMES
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  shw_pkg::shw_in_t    in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output shw_pkg::shw_out_t   out_data_o
);

  localparam int unsigned RING_LEN = FRAME_LEN * FRAMES;
  localparam int unsigned AW       = (RING_LEN > 1) ? $clog2(RING_LEN) : 1;

  logic                                 adv;
  logic                                 ring_we;
  logic [AW-1:0]                        ring_waddr;
  logic signed [shw_pkg::SAMPLE_W-1:0]  ring_wdata;
  logic                                 ring_re;
  logic [AW-1:0]                        ring_raddr;
  logic signed [shw_pkg::SAMPLE_W-1:0]  ring_rdata;
  shw_pkg::shw_tag_t                    issue_tag;
  logic                                 mul_vld;
  shw_pkg::shw_out_t                    mul_res;
  logic                                 out_vld_q;
  shw_pkg::shw_out_t                    out_data_q;

  // Advance the whole read pipeline whenever the output register is free or drains.
  assign adv = !out_vld_q || !out_stall_i;

  shw_ctrl #(
    .FRAME_LEN (FRAME_LEN),
    .FRAMES    (FRAMES),
    .RING_LEN  (RING_LEN),
    .AW        (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .adv_i      (adv),
    .we_o       (ring_we),
    .waddr_o    (ring_waddr),
    .wdata_o    (ring_wdata),
    .re_o       (ring_re),
    .raddr_o    (ring_raddr),
    .tag_o      (issue_tag)
  );

  shw_ring #(
    .DEPTH (RING_LEN),
    .AW    (AW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  shw_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .tag_i   (issue_tag),
    .rdata_i (ring_rdata),
    .vld_o   (mul_vld),
    .res_o   (mul_res)
  );

  // Output register: hold while stalled, load the next product otherwise.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= mul_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= mul_res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ----- rtl/core/shw_checker.sv -----
// Port-level checker for the window core, bound to the top level.
`default_nettype none

module shw_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_stall_o,
  input shw_pkg::shw_in_t   in_data_i,
  input wire                out_valid_o,
  input wire                out_stall_i,
  input shw_pkg::shw_out_t  out_data_o
);

  logic                   out_xfer;
  logic [shw_pkg::KW-1:0] cnt_q;

  assign out_xfer = out_valid_o && !out_stall_i;

  // Count result transfers within the current window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (out_xfer) begin
      cnt_q <= out_data_o.window_last ? '0 : cnt_q + shw_pkg::KW'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transfer dropped or changed while stalled");

  a_window_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> (out_data_o.window_last ==
                  (cnt_q == shw_pkg::KW'(shw_pkg::WINDOW_LEN - 1))))
    else $error("window_last not on the last value of a full window");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.func == shw_pkg::FUNC_CLEAR |=> in_stall_o)
    else $error("input taken during ring clearing sweep");

  a_reset_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o)
    else $error("input taken before the reset sweep");

endmodule

bind sliding_hamming_window_core shw_checker u_shw_checker (.*);

`default_nettype wire

// ----- verif/sliding_hamming_window_core_tb.sv -----
// Self-checking testbench for the sliding Hamming window core: random pushes, clears and stalls.
`default_nettype none

module sliding_hamming_window_core_tb;

  localparam int unsigned RING_LEN    = shw_pkg::SHW_FRAME_LEN * shw_pkg::SHW_FRAMES;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 27;
  localparam int unsigned MAX_REPORTS = 10;
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint ONE_Q30          = 64'sd1073741824;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  shw_pkg::shw_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  shw_pkg::shw_out_t out_data;

  // Shadow copy of the window state.
  logic signed [shw_pkg::SAMPLE_W-1:0] history_ring [RING_LEN];
  logic [shw_pkg::COEF_W-1:0]          hamming_coef [shw_pkg::WINDOW_LEN];
  int unsigned                         wr_frame;
  int unsigned                         rd_frame;
  int unsigned                         fill_idx;

  shw_pkg::shw_in_t  pending_items[$];
  shw_pkg::shw_out_t expected_windowed[$];
  shw_pkg::shw_out_t oldest_expected;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;

  sliding_hamming_window_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #1 clk = ~clk;

  // Periodic Hamming coefficient in Q1.15, cosine by a fixed-point Taylor series.
  function automatic logic [shw_pkg::COEF_W-1:0] hamming_q15(int unsigned k);
    int unsigned       m;
    longint unsigned   num;
    longint unsigned   den;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   divisor;
    longint            c;
    longint            v;
    longint            w;
    bit                neg;
    m   = k % shw_pkg::WINDOW_LEN;
    den = shw_pkg::WINDOW_LEN;
    neg = 1'b0;
    if (2 * m > shw_pkg::WINDOW_LEN) m = shw_pkg::WINDOW_LEN - m;
    num = 2 * m;
    // Past a quarter turn: mirror the angle and flip the sign.
    if (2 * num > den) begin
      neg = 1'b1;
      num = den - num;
    end
    x    = (PI_Q30 * num) / den;
    x2   = (x * x) >> 30;
    term = ONE_Q30;
    c    = ONE_Q30;
    for (int i = 1; i <= 10; i++) begin
      divisor = (2 * i - 1) * (2 * i);
      term    = ((term * x2) >> 30) / divisor;
      if (i % 2 == 1) c = c - longint'(term);
      else c = c + longint'(term);
    end
    if (neg) c = -c;
    v = 54 * ONE_Q30 - 46 * c;
    if (v < 0) v = 0;
    w = (v + 50 * 32768) / (100 * 32768);
    if (w > 32768) w = 32768;
    return w[shw_pkg::COEF_W-1:0];
  endfunction

  task automatic wipe_history();
    foreach (history_ring[i]) history_ring[i] = '0;
    wr_frame = shw_pkg::SHW_FRAMES - 1;
    rd_frame = 0;
    fill_idx = 0;
  endtask

  // Apply one accepted transfer to the shadow state; a completed frame queues a window.
  task automatic absorb_item(shw_pkg::shw_in_t item);
    int unsigned       base_pos;
    int unsigned       pos;
    longint            prod;
    shw_pkg::shw_out_t res;
    if (item.func == shw_pkg::FUNC_CLEAR) begin
      wipe_history();
      return;
    end
    history_ring[(wr_frame * shw_pkg::SHW_FRAME_LEN + fill_idx) % RING_LEN] = item.sample;
    fill_idx++;
    if (fill_idx < shw_pkg::SHW_FRAME_LEN) return;
    fill_idx = 0;
    wr_frame = (wr_frame + 1) % shw_pkg::SHW_FRAMES;
    base_pos = rd_frame * shw_pkg::SHW_FRAME_LEN;
    for (int unsigned k = 0; k < shw_pkg::WINDOW_LEN; k++) begin
      pos  = (base_pos + k) % RING_LEN;
      prod = longint'(history_ring[pos]) * longint'({1'b0, hamming_coef[k]});
      res.windowed_value = prod[shw_pkg::VALUE_W-1:0];
      res.window_last    = (k == shw_pkg::WINDOW_LEN - 1);
      expected_windowed.push_back(res);
    end
    rd_frame = (rd_frame + 1) % shw_pkg::SHW_FRAMES;
  endtask

  function automatic logic signed [shw_pkg::SAMPLE_W-1:0] random_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      default: return r[shw_pkg::SAMPLE_W-1:0];
    endcase
  endfunction

  task automatic queue_item(logic func, logic signed [shw_pkg::SAMPLE_W-1:0] s);
    shw_pkg::shw_in_t it;
    it.func   = func;
    it.sample = s;
    pending_items.push_back(it);
  endtask

  // Hold until every queued item is taken and every window has come out.
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_windowed.size() != 0)
      @(negedge clk);
  endtask

  // Driver: predict on each transfer, then offer the next item or idle.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) absorb_item(in_data);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: compare each result transfer with the oldest expected value.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_windowed.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("ERROR: unexpected result value %0d last %0b",
                   out_data.windowed_value, out_data.window_last);
      end else begin
        oldest_expected = expected_windowed.pop_front();
        if (out_data.windowed_value !== oldest_expected.windowed_value ||
            out_data.window_last !== oldest_expected.window_last) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("ERROR: expected value %0d last %0b, got value %0d last %0b",
                     oldest_expected.windowed_value, oldest_expected.window_last,
                     out_data.windowed_value, out_data.window_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic signed [shw_pkg::SAMPLE_W-1:0] extremes [16];
    int unsigned idle_plan  [4];
    int unsigned stall_plan [4];
    extremes   = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001, 16'sh8001,
                   16'sh5555, 16'shaaaa, 16'sh4000, 16'shc000, 16'sh00ff, 16'shff00,
                   16'sh0f0f, 16'shf0f0, 16'sh0100, 16'shff00};
    idle_plan  = '{0, 82, 0, 20};
    stall_plan = '{0, 0, 82, 20};
    wipe_history();
    for (int unsigned k = 0; k < shw_pkg::WINDOW_LEN; k++) hamming_coef[k] = hamming_q15(k);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a partial frame dropped by back-to-back clears, then a frame of extremes.
    @(negedge clk);
    queue_item(shw_pkg::FUNC_PUSH, 16'sh0001);
    queue_item(shw_pkg::FUNC_PUSH, 16'shfffe);
    queue_item(shw_pkg::FUNC_PUSH, 16'sh1234);
    queue_item(shw_pkg::FUNC_CLEAR, 16'sh7fff);
    queue_item(shw_pkg::FUNC_CLEAR, 16'sh8000);
    foreach (extremes[i]) queue_item(shw_pkg::FUNC_PUSH, extremes[i]);
    drain();

    // Random phases; each drains fully before the next pacing takes effect.
    for (int p = 0; p < 4; p++) begin
      @(negedge clk);
      send_idle_pct  = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      for (int n = 0; n < PHASE_ITEMS; n++)
        queue_item(($urandom_range(39) == 0) ? shw_pkg::FUNC_CLEAR : shw_pkg::FUNC_PUSH,
                   random_sample());
      drain();
    end

    // Let any stray result surface before the verdict.
    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_windowed.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
